// File: rtl/core/order_statistic_multiset_assert.svh
// Assertion macros used by the checker of this block.
`ifndef ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define ORDER_STATISTIC_MULTISET_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define OSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: rtl/core/osm_pkg.sv
package osm_pkg;

    localparam int DISTINCT_CAPACITY = 256;
    localparam int MAX_TOTAL         = 65536;

    localparam int KEY_W  = 32;
    localparam int CNT_W  = 17;
    localparam int ADDR_W = $clog2(DISTINCT_CAPACITY);
    localparam int USED_W = $clog2(DISTINCT_CAPACITY + 1);

    localparam logic [USED_W-1:0] CAP_FULL  = USED_W'(DISTINCT_CAPACITY);
    localparam logic [CNT_W-1:0]  TOTAL_MAX = CNT_W'(MAX_TOTAL);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_RANK   = 2'd1,
        OP_SELECT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    // Access to the key/count table: one write and one read per cycle.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wkey;
        logic [CNT_W-1:0]  wcnt;
        logic [ADDR_W-1:0] raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] rkey;
        logic [CNT_W-1:0] rcnt;
    } tbl_rsp_t;

endpackage

// File: rtl/core/osm_table.sv
module osm_table (
    input  logic              aclk,
    input  osm_pkg::tbl_req_t req,
    output osm_pkg::tbl_rsp_t rsp
);

    logic [osm_pkg::KEY_W-1:0] key_mem [osm_pkg::DISTINCT_CAPACITY];
    logic [osm_pkg::CNT_W-1:0] cnt_mem [osm_pkg::DISTINCT_CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            key_mem[req.waddr] <= req.wkey;
            cnt_mem[req.waddr] <= req.wcnt;
        end
        rsp.rkey <= key_mem[req.raddr];
        rsp.rcnt <= cnt_mem[req.raddr];
    end

endmodule

// File: rtl/core/osm_seq.sv
module osm_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  osm_pkg::op_t               in_op,
    input  logic [osm_pkg::KEY_W-1:0]  in_key,
    input  logic [osm_pkg::CNT_W-1:0]  in_rank,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [osm_pkg::CNT_W-1:0]  out_cnt,
    output logic [osm_pkg::KEY_W-1:0]  out_key,
    output osm_pkg::status_t           out_status,
    output osm_pkg::tbl_req_t          tbl_req,
    input  osm_pkg::tbl_rsp_t          tbl_rsp
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_EV  = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    osm_pkg::op_t                   op_reg, op_next;
    logic [osm_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [osm_pkg::CNT_W-1:0]      want_reg, want_next;
    logic [osm_pkg::USED_W-1:0]     idx_reg, idx_next;
    logic [osm_pkg::USED_W-1:0]     pos_reg, pos_next;
    logic [osm_pkg::CNT_W-1:0]      acc_reg, acc_next;
    logic [osm_pkg::USED_W-1:0]     used_reg, used_next;
    logic [osm_pkg::CNT_W-1:0]      total_reg, total_next;
    logic [osm_pkg::CNT_W-1:0]      res_cnt_reg, res_cnt_next;
    logic [osm_pkg::KEY_W-1:0]      res_key_reg, res_key_next;
    osm_pkg::status_t               res_st_reg, res_st_next;
    logic                           ov_reg, ov_next;
    logic [osm_pkg::CNT_W-1:0]      oc_reg, oc_next;
    logic [osm_pkg::KEY_W-1:0]      ok_reg, ok_next;
    osm_pkg::status_t               os_reg, os_next;
    logic [osm_pkg::CNT_W-1:0]      acc_sum;
    logic [osm_pkg::USED_W-1:0]     idx_dec;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign out_cnt    = oc_reg;
    assign out_key    = ok_reg;
    assign out_status = os_reg;
    assign acc_sum    = acc_reg + tbl_rsp.rcnt;
    assign idx_dec    = idx_reg - osm_pkg::USED_W'(1);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        want_next    = want_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        acc_next     = acc_reg;
        used_next    = used_reg;
        total_next   = total_reg;
        res_cnt_next = res_cnt_reg;
        res_key_next = res_key_reg;
        res_st_next  = res_st_reg;
        ov_next      = ov_reg && !out_ready;
        oc_next      = oc_reg;
        ok_next      = ok_reg;
        os_next      = os_reg;
        tbl_req      = '0;
        tbl_req.raddr = idx_reg[osm_pkg::ADDR_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next      = in_op;
                    key_next     = in_key;
                    want_next    = in_rank;
                    idx_next     = '0;
                    acc_next     = '0;
                    res_cnt_next = '0;
                    res_key_next = '0;
                    res_st_next  = osm_pkg::ST_OK;
                    state_next   = S_SCAN_RD;
                    case (in_op)
                        osm_pkg::OP_INSERT: begin
                            if (total_reg >= osm_pkg::TOTAL_MAX) begin
                                res_st_next = osm_pkg::ST_SATURATED;
                                state_next  = S_DONE;
                            end
                        end
                        osm_pkg::OP_SELECT: begin
                            if (in_rank == '0 || in_rank > total_reg) begin
                                res_st_next = osm_pkg::ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        osm_pkg::OP_RANK: ;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == used_reg) begin
                    state_next = S_DONE;
                    case (op_reg)
                        osm_pkg::OP_INSERT: begin
                            if (used_reg == osm_pkg::CAP_FULL) begin
                                res_st_next = osm_pkg::ST_FULL;
                            end else begin
                                pos_next   = idx_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                        osm_pkg::OP_RANK: res_cnt_next = acc_reg;
                        default: res_st_next = osm_pkg::ST_RANGE;
                    endcase
                end else begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                idx_next   = idx_reg + osm_pkg::USED_W'(1);
                state_next = S_SCAN_RD;
                case (op_reg)
                    osm_pkg::OP_INSERT: begin
                        if ($signed(key_reg) <= $signed(tbl_rsp.rkey)) begin
                            idx_next   = idx_reg;
                            state_next = S_DONE;
                            if (key_reg == tbl_rsp.rkey) begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = idx_reg[osm_pkg::ADDR_W-1:0];
                                tbl_req.wkey  = tbl_rsp.rkey;
                                tbl_req.wcnt  = tbl_rsp.rcnt + osm_pkg::CNT_W'(1);
                                total_next    = total_reg + osm_pkg::CNT_W'(1);
                            end else if (used_reg == osm_pkg::CAP_FULL) begin
                                res_st_next = osm_pkg::ST_FULL;
                            end else begin
                                pos_next   = idx_reg;
                                idx_next   = used_reg;
                                state_next = S_SHIFT_RD;
                            end
                        end
                    end
                    osm_pkg::OP_RANK: begin
                        if ($signed(tbl_rsp.rkey) <= $signed(key_reg)) begin
                            acc_next = acc_sum;
                        end else begin
                            res_cnt_next = acc_reg;
                            state_next   = S_DONE;
                        end
                    end
                    default: begin
                        acc_next = acc_sum;
                        if (acc_sum >= want_reg) begin
                            res_key_next = tbl_rsp.rkey;
                            state_next   = S_DONE;
                        end
                    end
                endcase
            end
            S_SHIFT_RD: begin
                // move entries up one slot, top first, then drop the new key in
                if (idx_reg == pos_reg) begin
                    tbl_req.we    = 1'b1;
                    tbl_req.waddr = pos_reg[osm_pkg::ADDR_W-1:0];
                    tbl_req.wkey  = key_reg;
                    tbl_req.wcnt  = osm_pkg::CNT_W'(1);
                    used_next     = used_reg + osm_pkg::USED_W'(1);
                    total_next    = total_reg + osm_pkg::CNT_W'(1);
                    state_next    = S_DONE;
                end else begin
                    tbl_req.raddr = idx_dec[osm_pkg::ADDR_W-1:0];
                    state_next    = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                tbl_req.we    = 1'b1;
                tbl_req.waddr = idx_reg[osm_pkg::ADDR_W-1:0];
                tbl_req.wkey  = tbl_rsp.rkey;
                tbl_req.wcnt  = tbl_rsp.rcnt;
                idx_next      = idx_dec;
                state_next    = S_SHIFT_RD;
            end
            S_DONE: begin
                if (!ov_reg || out_ready) begin
                    ov_next    = 1'b1;
                    oc_next    = res_cnt_reg;
                    ok_next    = res_key_reg;
                    os_next    = res_st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            total_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            total_reg <= total_next;
            ov_reg    <= ov_next;
        end
        op_reg      <= op_next;
        key_reg     <= key_next;
        want_reg    <= want_next;
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        res_cnt_reg <= res_cnt_next;
        res_key_reg <= res_key_next;
        res_st_reg  <= res_st_next;
        oc_reg      <= oc_next;
        ok_reg      <= ok_next;
        os_reg      <= os_next;
    end

endmodule

// File: rtl/core/order_statistic_multiset.sv
// Multiset of signed 32-bit keys with insert, rank (count of keys <= key) and
// select (k-th smallest, one-based). Keys live in a sorted table of up to 256
// distinct values with a count each, held in a single-port-read RAM with a
// registered read. One request is served at a time. Rank and select walk the
// table from the bottom; an insert walks to its slot, then a new key shifts
// every entry above it up one slot. A saturated insert, an out-of-range
// select and the unused op skip the table; a new key offered to a full table
// is flagged when the walk reaches its slot.
// A finished result sits in an output register, so the next request is taken
// while it waits.
module order_statistic_multiset (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key[31:0], wanted_rank[48:32], zero fill
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // count_answer[16:0], key_answer[48:17], zero fill
    output logic [1:0]  m_tuser    // status[1:0]
);

    osm_pkg::tbl_req_t               tbl_req;
    osm_pkg::tbl_rsp_t               tbl_rsp;
    logic [osm_pkg::CNT_W-1:0]       out_cnt;
    logic [osm_pkg::KEY_W-1:0]       out_key;
    osm_pkg::status_t                out_status;

    osm_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (osm_pkg::op_t'(s_tuser)),
        .in_key     (s_tdata[31:0]),
        .in_rank    (s_tdata[48:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_cnt    (out_cnt),
        .out_key    (out_key),
        .out_status (out_status),
        .tbl_req    (tbl_req),
        .tbl_rsp    (tbl_rsp)
    );

    osm_table u_table (
        .aclk (aclk),
        .req  (tbl_req),
        .rsp  (tbl_rsp)
    );

    assign m_tdata = {7'b0, out_key, out_cnt};
    assign m_tuser = out_status;

endmodule

// File: rtl/core/osm_checker.sv
`include "order_statistic_multiset_assert.svh"

module osm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one request in flight: input closes right after a transfer
    `OSM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // rejected requests carry no answer
    `OSM_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_tvalid && m_tuser != osm_pkg::ST_OK, m_tdata == 56'd0)
    // at most one answer field is nonzero
    `OSM_ASSERT_IMPL(a_one_answer, aclk, aresetn, m_tvalid && m_tdata[16:0] != 17'd0, m_tdata[48:17] == 32'd0)
    `OSM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
